/* design/mege_pkg.sv */
`timescale 1ns / 1ps

package mege_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned OUT_BITS   = 12;
  localparam int unsigned POS_BITS   = COORD_BITS + 1;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
  localparam int unsigned MUL_BITS   = 2 * POS_BITS;
  localparam int unsigned PROD_BITS  = 2 * MUL_BITS;
  localparam int unsigned STEP_BITS  = 34;
  localparam int unsigned DEC_BITS   = 48;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius_x;
    logic [COORD_BITS-1:0] radius_y;
  } mege_req_t;

  typedef struct packed {
    logic                       valid_res;
    logic signed [OUT_BITS-1:0] px_a;
    logic signed [OUT_BITS-1:0] py_a;
    logic signed [OUT_BITS-1:0] px_b;
    logic signed [OUT_BITS-1:0] py_b;
    logic signed [OUT_BITS-1:0] px_c;
    logic signed [OUT_BITS-1:0] py_c;
    logic signed [OUT_BITS-1:0] px_d;
    logic signed [OUT_BITS-1:0] py_d;
    logic                       last;
  } mege_res_t;

endpackage

/* design/mege_if.sv */
`timescale 1ns / 1ps

interface mege_req_if;
  import mege_pkg::*;
  logic      valid;
  logic      ready;
  mege_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mege_res_if;
  import mege_pkg::*;
  logic      valid;
  logic      ready;
  mege_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/midpoint_ellipse_generator_unit.sv */
`timescale 1ns / 1ps
// A point is registered onto res_o and appears there in the cycle after its request transfer.
// A step request runs the update states ST_ADV1 and ST_ADV2; the step that enters
// region 2 adds ST_RC1..ST_RC6 on the shared multiplier; a start request runs ST_SQ_RX,
// ST_SQ_RY, ST_A_RY (squares and a*ry on the multiplier), ST_INIT, ST_ADV1 and ST_ADV2.
// Reset (rst_ni low, async): idle, no ellipse active, output empty.
module midpoint_ellipse_generator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  mege_req_if.sink   req_i,
  mege_res_if.source res_o
);
  import mege_pkg::*;

  // One-hot sequencer
  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SQ_RX = 13'b0000000000010, // rx*rx
    ST_SQ_RY = 13'b0000000000100, // a = p, ry*ry
    ST_A_RY  = 13'b0000000001000, // b = p, a*ry
    ST_INIT  = 13'b0000000010000, // dy, initial decision
    ST_ADV1  = 13'b0000000100000, // position and step terms
    ST_ADV2  = 13'b0000001000000, // decision update, region check
    ST_RC1   = 13'b0000010000000, // hx*hx
    ST_RC2   = 13'b0000100000000, // b*hx^2
    ST_RC3   = 13'b0001000000000, // d = p, ym*ym
    ST_RC4   = 13'b0010000000000, // a*ym^2
    ST_RC5   = 13'b0100000000000, // d += 4p, a*b
    ST_RC6   = 13'b1000000000000  // d -= 4p
  } state_e;

  state_e state_q, state_d;

  logic                         active_q;
  logic                         region2_q;
  logic                         br_q;
  logic [POS_BITS-1:0]          pos_x_q;
  logic [POS_BITS-1:0]          pos_y_q;
  logic signed [DEC_BITS-1:0]   dec_q;
  logic signed [STEP_BITS-1:0]  dx_q;
  logic signed [STEP_BITS-1:0]  dy_q;
  logic [COORD_BITS-1:0]        cx_q;
  logic [COORD_BITS-1:0]        cy_q;
  logic [COORD_BITS-1:0]        rx_q;
  logic [COORD_BITS-1:0]        ry_q;
  logic [SQ_BITS-1:0]           a_q;
  logic [SQ_BITS-1:0]           b_q;
  logic                         out_valid_q;
  mege_res_t                    out_q;

  logic                  in_xfer;
  logic                  is_start;
  logic [COORD_BITS-1:0] rx_in;
  logic [COORD_BITS-1:0] ry_in;

  logic [MUL_BITS-1:0]   mul_a;
  logic [MUL_BITS-1:0]   mul_b;
  logic [PROD_BITS-1:0]  prod;

  logic signed [DEC_BITS-1:0] a_ext, b_ext, dx_ext, dy_ext, p_ext;
  logic [POS_BITS:0]          hx;
  logic [POS_BITS-1:0]        ym_abs;

  // Result selection for the point being emitted
  logic [COORD_BITS-1:0] sel_cx, sel_cy;
  logic [POS_BITS-1:0]   sel_x, sel_y;
  logic                  sel_last;
  logic                  sel_valid;
  logic [OUT_BITS-1:0]   xp, xm, yp, ym_o;
  mege_res_t             res_d;

  assign in_xfer     = req_i.valid & req_i.ready;
  assign is_start    = (req_i.data.req_type == REQ_START);
  assign req_i.ready = (state_q == ST_IDLE) & (~out_valid_q | res_o.ready);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Zero radius behaves as radius 1
  assign rx_in = (req_i.data.radius_x == '0) ? COORD_BITS'(1) : req_i.data.radius_x;
  assign ry_in = (req_i.data.radius_y == '0) ? COORD_BITS'(1) : req_i.data.radius_y;

  assign a_ext  = DEC_BITS'(a_q);
  assign b_ext  = DEC_BITS'(b_q);
  assign dx_ext = DEC_BITS'(dx_q);
  assign dy_ext = DEC_BITS'(dy_q);
  assign p_ext  = DEC_BITS'(prod);

  assign hx     = {pos_x_q, 1'b1};
  // y never drops below zero, so |y-1| is 1 at y = 0
  assign ym_abs = (pos_y_q == '0) ? POS_BITS'(1) : pos_y_q - POS_BITS'(1);

  always_comb begin
    sel_valid = 1'b1;
    sel_last  = 1'b0;
    if (is_start) begin
      sel_cx = req_i.data.center_x;
      sel_cy = req_i.data.center_y;
      sel_x  = '0;
      sel_y  = POS_BITS'(ry_in);
    end else begin
      sel_cx = cx_q;
      sel_cy = cy_q;
      sel_x  = pos_x_q;
      sel_y  = pos_y_q;
      sel_last = region2_q & (pos_y_q <= POS_BITS'(1));
      if (!active_q) begin
        sel_valid = 1'b0;
      end
    end
    xp   = OUT_BITS'(sel_cx) + OUT_BITS'(sel_x);
    xm   = OUT_BITS'(sel_cx) - OUT_BITS'(sel_x);
    yp   = OUT_BITS'(sel_cy) + OUT_BITS'(sel_y);
    ym_o = OUT_BITS'(sel_cy) - OUT_BITS'(sel_y);
    res_d.valid_res = sel_valid;
    res_d.px_a = xp;
    res_d.py_a = yp;
    res_d.px_b = xm;
    res_d.py_b = ym_o;
    res_d.px_c = xp;
    res_d.py_c = ym_o;
    res_d.px_d = xm;
    res_d.py_d = yp;
    res_d.last = sel_last;
    if (!sel_valid) begin
      res_d = '0;
    end
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_RX: begin
        mul_a = MUL_BITS'(rx_q);
        mul_b = MUL_BITS'(rx_q);
      end
      ST_SQ_RY: begin
        mul_a = MUL_BITS'(ry_q);
        mul_b = MUL_BITS'(ry_q);
      end
      ST_A_RY: begin
        mul_a = MUL_BITS'(a_q);
        mul_b = MUL_BITS'(ry_q);
      end
      ST_RC1: begin
        mul_a = MUL_BITS'(hx);
        mul_b = MUL_BITS'(hx);
      end
      ST_RC2: begin
        mul_a = MUL_BITS'(b_q);
        mul_b = prod[MUL_BITS-1:0];
      end
      ST_RC3: begin
        mul_a = MUL_BITS'(ym_abs);
        mul_b = MUL_BITS'(ym_abs);
      end
      ST_RC4: begin
        mul_a = MUL_BITS'(a_q);
        mul_b = prod[MUL_BITS-1:0];
      end
      ST_RC5: begin
        mul_a = MUL_BITS'(a_q);
        mul_b = MUL_BITS'(b_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mege_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_start) begin
            state_d = ST_SQ_RX;
          end else if (active_q && !sel_last) begin
            state_d = ST_ADV1;
          end
        end
      end
      ST_SQ_RX: state_d = ST_SQ_RY;
      ST_SQ_RY: state_d = ST_A_RY;
      ST_A_RY:  state_d = ST_INIT;
      ST_INIT:  state_d = ST_ADV1;
      ST_ADV1:  state_d = ST_ADV2;
      ST_ADV2: begin
        if (!region2_q && (dx_q >= dy_q)) begin
          state_d = ST_RC1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RC1: state_d = ST_RC2;
      ST_RC2: state_d = ST_RC3;
      ST_RC3: state_d = ST_RC4;
      ST_RC4: state_d = ST_RC5;
      ST_RC5: state_d = ST_RC6;
      ST_RC6: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      region2_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
        if (is_start) begin
          active_q  <= 1'b1;
          region2_q <= 1'b0;
        end else if (sel_last) begin
          active_q <= 1'b0;
        end
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_ADV2) && !region2_q && (dx_q >= dy_q)) begin
        region2_q <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= res_d;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_start) begin
          cx_q    <= req_i.data.center_x;
          cy_q    <= req_i.data.center_y;
          rx_q    <= rx_in;
          ry_q    <= ry_in;
          pos_x_q <= '0;
          pos_y_q <= POS_BITS'(ry_in);
          dx_q    <= '0;
        end
      end
      ST_SQ_RY: a_q <= prod[SQ_BITS-1:0];
      ST_A_RY:  b_q <= prod[SQ_BITS-1:0];
      ST_INIT: begin
        dy_q  <= STEP_BITS'(prod) <<< 1;
        dec_q <= (b_ext <<< 2) - (p_ext <<< 2) + a_ext;
      end
      ST_ADV1: begin
        if (!region2_q) begin
          pos_x_q <= pos_x_q + POS_BITS'(1);
          dx_q    <= dx_q + (STEP_BITS'(b_q) <<< 1);
          br_q    <= dec_q < 0;
          if (dec_q >= 0) begin
            pos_y_q <= pos_y_q - POS_BITS'(1);
            dy_q    <= dy_q - (STEP_BITS'(a_q) <<< 1);
          end
        end else begin
          pos_y_q <= pos_y_q - POS_BITS'(1);
          dy_q    <= dy_q - (STEP_BITS'(a_q) <<< 1);
          br_q    <= dec_q > 0;
          if (dec_q <= 0) begin
            pos_x_q <= pos_x_q + POS_BITS'(1);
            dx_q    <= dx_q + (STEP_BITS'(b_q) <<< 1);
          end
        end
      end
      ST_ADV2: begin
        if (!region2_q) begin
          if (br_q) begin
            dec_q <= dec_q + ((dx_ext + b_ext) <<< 2);
          end else begin
            dec_q <= dec_q + ((dx_ext - dy_ext + b_ext) <<< 2);
          end
        end else begin
          if (br_q) begin
            dec_q <= dec_q + ((a_ext - dy_ext) <<< 2);
          end else begin
            dec_q <= dec_q + ((dx_ext - dy_ext + a_ext) <<< 2);
          end
        end
      end
      ST_RC3: dec_q <= p_ext;
      ST_RC5: dec_q <= dec_q + (p_ext <<< 2);
      ST_RC6: dec_q <= dec_q - (p_ext <<< 2);
      default: begin
      end
    endcase
  end

endmodule

/* design/mege_mul.sv */
`timescale 1ns / 1ps

// Shared unsigned multiplier, product registered.
module mege_mul (
  input  logic                           clk_i,
  input  logic [mege_pkg::MUL_BITS-1:0]  op_a_i,
  input  logic [mege_pkg::MUL_BITS-1:0]  op_b_i,
  output logic [mege_pkg::PROD_BITS-1:0] prod_o
);
  import mege_pkg::*;

  logic [PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'(op_a_i) * PROD_BITS'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule
